FILE: sv/bcp_pkg.sv
// Shared types, register codes and constants of the braking collision probability block.
package bcp_pkg;

  typedef struct packed {
    logic [19:0] gap_mm;
    logic [15:0] speed_kmh_q8;
  } in_word_t;

  typedef struct packed {
    logic [23:0] stop_distance_mm;
    logic [15:0] collision_prob;
    logic        distance_saturated;
  } out_word_t;

  typedef struct packed {
    logic [11:0] reaction_ms;
    logic [11:0] activation_ms;
    logic [11:0] pressure_rise_ms;
    logic [14:0] decel_mm_s2;
    logic [15:0] spread_fraction;
  } cfg_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgReaction  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgActivation = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPressure  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDecel     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSpread    = 3'd4;

  localparam cfg_t CfgReset = '{
    reaction_ms:      12'd1100,
    activation_ms:    12'd500,
    pressure_rise_ms: 12'd200,
    decel_mm_s2:      15'd9000,
    spread_fraction:  16'd6554
  };

  localparam int GapW     = 20;
  localparam int NumW     = 43;
  localparam int DivisorW = 22;
  localparam int MeanW    = 32;

  localparam logic [23:0] DistMax = 24'hFFFFFF;

  localparam int unsigned KnotLast = 36;

  localparam logic [15:0] TailKnots [37] = '{
    16'd32768, 16'd29508, 16'd26299, 16'd23189, 16'd20220, 16'd17432, 16'd14852, 16'd12503,
    16'd10398, 16'd8539,  16'd6924,  16'd5542,  16'd4378,  16'd3413,  16'd2625,  16'd1992,
    16'd1491,  16'd1101,  16'd801,   16'd575,   16'd407,   16'd284,   16'd195,   16'd132,
    16'd88,    16'd58,    16'd38,    16'd24,    16'd15,    16'd9,     16'd6,     16'd3,
    16'd2,     16'd1,     16'd1,     16'd0,     16'd0
  };

endpackage

FILE: sv/bcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module bcp_div #(
  parameter int NW = 43,
  parameter int DW = 22,
  parameter int QW = 32,
  parameter int SW = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [QW-1:0] v_q;
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] lw_q   [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  logic [DW-1:0] rem_in  [QW];
  logic [QW-1:0] lw_in   [QW];
  logic [DW-1:0] den_in  [QW];
  logic [SW-1:0] side_in [QW];
  logic [DW:0]   trial   [QW];
  logic [QW-1:0] ge;
  logic [DW-1:0] rem_d   [QW];
  logic [QW-1:0] lw_d    [QW];

  always_comb begin
    rem_in[0]  = DW'(num_i >> QW);
    lw_in[0]   = num_i[QW-1:0];
    den_in[0]  = den_i;
    side_in[0] = side_i;
    for (int i = 1; i < QW; i++) begin
      rem_in[i]  = rem_q[i-1];
      lw_in[i]   = lw_q[i-1];
      den_in[i]  = den_q[i-1];
      side_in[i] = side_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      trial[i] = {rem_in[i], lw_in[i][QW-1]};
      ge[i]    = trial[i] >= {1'b0, den_in[i]};
      rem_d[i] = ge[i] ? DW'(trial[i] - {1'b0, den_in[i]}) : trial[i][DW-1:0];
      lw_d[i]  = {lw_in[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i]  <= rem_d[i];
        lw_q[i]   <= lw_d[i];
        den_q[i]  <= den_in[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = lw_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

FILE: sv/bcp_dist.sv
// Front stages: speed products and the numerator and divisor of the mean distance.
module bcp_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  bcp_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  input  bcp_pkg::in_word_t            word_i,
  output logic                         valid_o,
  output logic [bcp_pkg::NumW-1:0]     num_o,
  output logic [bcp_pkg::DivisorW-1:0] den_o,
  output logic [bcp_pkg::GapW-1:0]     gap_o
);
  import bcp_pkg::*;

  logic [3:0]  v_q;
  logic [14:0] time_hms;
  logic [14:0] decel;

  logic [15:0]     speed1_q;
  logic [GapW-1:0] gap1_q;
  logic [30:0]     st_q;
  logic [31:0]     ss_q;
  logic [GapW-1:0] gap2_q;
  logic [45:0]     a1_q;
  logic [50:0]     b1_q;
  logic [34:0]     half_q;
  logic [DivisorW-1:0] den3_q;
  logic [GapW-1:0] gap3_q;
  logic [NumW-1:0] num_q;
  logic [DivisorW-1:0] den4_q;
  logic [GapW-1:0] gap4_q;

  logic [55:0] sum_d;

  assign time_hms = 15'({cfg_i.reaction_ms, 1'b0}) + 15'({cfg_i.activation_ms, 1'b0})
                  + 15'(cfg_i.pressure_rise_ms);
  assign decel = (cfg_i.decel_mm_s2 == '0) ? 15'd1 : cfg_i.decel_mm_s2;
  assign sum_d = {10'd0, a1_q} * 56'd360 + {5'd0, b1_q} + {21'd0, half_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      speed1_q <= word_i.speed_kmh_q8;
      gap1_q   <= word_i.gap_mm;
      st_q     <= {15'd0, speed1_q} * {16'd0, time_hms};
      ss_q     <= {16'd0, speed1_q} * {16'd0, speed1_q};
      gap2_q   <= gap1_q;
      a1_q     <= {15'd0, st_q} * {31'd0, decel};
      b1_q     <= {19'd0, ss_q} * 51'd390625;
      half_q   <= {20'd0, decel} * 35'd331776;
      den3_q   <= {7'd0, decel} * 22'd81;
      gap3_q   <= gap2_q;
      num_q    <= sum_d[55:13];
      den4_q   <= den3_q;
      gap4_q   <= gap3_q;
    end
  end

  assign valid_o = v_q[3];
  assign num_o   = num_q;
  assign den_o   = den4_q;
  assign gap_o   = gap4_q;

endmodule

FILE: sv/bcp_prob.sv
// Back stages: deviation, table index division, tail table and output register.
module bcp_prob #(
  parameter int unsigned Entries = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  bcp_pkg::cfg_t             cfg_i,
  input  logic                      valid_i,
  input  logic [bcp_pkg::MeanW-1:0] mean_i,
  input  logic [bcp_pkg::GapW-1:0]  gap_i,
  output logic                      valid_o,
  output bcp_pkg::out_word_t        word_o
);
  import bcp_pkg::*;

  localparam int EntW     = $clog2(Entries + 1);
  localparam int IdxW     = $clog2(Entries);
  localparam int RomDepth = 2 ** IdxW;
  localparam int AeW      = MeanW + EntW;
  localparam int Num2W    = AeW + 13;
  localparam int SgW      = 48;
  localparam int SideW    = 28;

  logic [15:0] spread;
  assign spread = (cfg_i.spread_fraction == '0) ? 16'd1 : cfg_i.spread_fraction;

  // deviation stage
  logic            above_d, sat_d;
  logic [MeanW-1:0] a_d;
  logic [23:0]     dist_d;
  logic            v1_q, above1_q, mzero1_q, sat1_q;
  logic [MeanW-1:0] a1_q, mean1_q;
  logic [23:0]     dist1_q;

  assign above_d = {12'd0, gap_i} >= mean_i;
  assign a_d     = above_d ? ({12'd0, gap_i} - mean_i) : (mean_i - {12'd0, gap_i});
  assign sat_d   = mean_i > {8'd0, DistMax};
  assign dist_d  = sat_d ? DistMax : mean_i[23:0];

  // product stage
  logic            v2_q, above2_q, mzero2_q, sat2_q;
  logic [MeanW-1:0] a2_q;
  logic [SgW-1:0]  sg_q;
  logic [AeW-1:0]  ae_q;
  logic [23:0]     dist2_q;

  // range stage
  logic            v3_q, inr3_q, above3_q, mzero3_q, sat3_q;
  logic [Num2W-1:0] num3_q;
  logic [SgW-1:0]  den3_q;
  logic [23:0]     dist3_q;

  logic            dv_valid;
  logic [IdxW-1:0] dv_idx;
  logic [SideW-1:0] dv_side;

  bcp_div #(
    .NW(Num2W),
    .DW(SgW),
    .QW(IdxW),
    .SW(SideW)
  ) u_idx_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(v3_q),
    .num_i  (num3_q),
    .den_i  (den3_q),
    .side_i ({inr3_q, above3_q, mzero3_q, sat3_q, dist3_q}),
    .valid_o(dv_valid),
    .quo_o  (dv_idx),
    .side_o (dv_side)
  );

  // tail table
  logic [15:0] tail_rom [RomDepth];

  for (genvar i = 0; i < RomDepth; i++) begin : g_rom
    localparam int unsigned Pos = 64 * i;
    localparam int unsigned J   = Pos / Entries;
    localparam int unsigned R   = Pos % Entries;
    localparam int unsigned Jc  = (J < KnotLast) ? J : KnotLast - 1;
    localparam int unsigned Hi  = TailKnots[Jc];
    localparam int unsigned Lo  = TailKnots[Jc + 1];
    localparam int unsigned V   = Hi * Entries - (Hi - Lo) * R;
    localparam int unsigned Val = (J < KnotLast && i < Entries) ?
                                  (V + Entries / 2) / Entries : 0;
    assign tail_rom[i] = 16'(Val);
  end

  logic        v4_q, inr4_q, above4_q, mzero4_q, sat4_q;
  logic [15:0] tail_q;
  logic [23:0] dist4_q;

  logic        v5_q;
  out_word_t   word_q;
  logic [15:0] prob_d;

  always_comb begin
    if (mzero4_q) begin
      prob_d = '0;
    end else if (above4_q) begin
      prob_d = tail_q;
    end else if (tail_q == '0) begin
      prob_d = 16'hFFFF;
    end else begin
      prob_d = 16'(17'h10000 - {1'b0, tail_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= dv_valid;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      above1_q <= above_d;
      mzero1_q <= mean_i == '0;
      sat1_q   <= sat_d;
      a1_q     <= a_d;
      mean1_q  <= mean_i;
      dist1_q  <= dist_d;

      above2_q <= above1_q;
      mzero2_q <= mzero1_q;
      sat2_q   <= sat1_q;
      a2_q     <= a1_q;
      sg_q     <= {32'd0, spread} * {16'd0, mean1_q};
      ae_q     <= {{EntW{1'b0}}, a1_q} * AeW'(Entries);
      dist2_q  <= dist1_q;

      inr3_q   <= {3'd0, a2_q, 13'd0} < sg_q;
      above3_q <= above2_q;
      mzero3_q <= mzero2_q;
      sat3_q   <= sat2_q;
      num3_q   <= {ae_q, 13'd0};
      den3_q   <= sg_q;
      dist3_q  <= dist2_q;

      inr4_q   <= dv_side[27];
      above4_q <= dv_side[26];
      mzero4_q <= dv_side[25];
      sat4_q   <= dv_side[24];
      dist4_q  <= dv_side[23:0];
      tail_q   <= dv_side[27] ? tail_rom[dv_idx] : 16'd0;

      word_q.stop_distance_mm   <= dist4_q;
      word_q.collision_prob     <= prob_d;
      word_q.distance_saturated <= sat4_q;
    end
  end

  assign valid_o = v5_q;
  assign word_o  = word_q;

`ifndef SYNTH
  a_tail_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !inr4_q |-> tail_q == 16'd0)
    else $error("tail nonzero outside table range");
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> tail_q <= 16'd32768)
    else $error("tail above one half");
  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && word_o.distance_saturated |-> word_o.stop_distance_mm == DistMax)
    else $error("saturated distance not clamped");
`endif

endmodule

FILE: sv/braking_collision_probability.sv
// Top level of the braking collision probability block.
//
// Input channel: in_valid_i / in_stall_o carry one word with gap and speed.
// Output channel: out_valid_o / out_stall_i carry one word per input word with
// mean stopping distance, collision probability and a saturation flag.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i selecting
// reaction, activation, pressure rise, deceleration or spread; ready is always
// high, unknown indexes are ignored. Write only while the pipeline is empty.
// The pipeline has four product stages, a 32-stage mean distance divider, three
// deviation stages, one stage per table index bit, the table read and the output
// register. It takes one word per cycle while the receiver does not stall a
// valid output word.
// Reset clears all valid bits and loads the default register values.
// When the receiver stalls a valid output word, the whole pipeline holds and
// in_stall_o is raised in the same cycle; nothing is lost or repeated.
module braking_collision_probability #(
  parameter int unsigned CDF_TABLE_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bcp_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bcp_pkg::out_word_t           out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bcp_pkg::CfgDataW-1:0] cfg_data_i
);
  import bcp_pkg::*;

  cfg_t cfg_q;
  logic en;

  logic                dist_valid;
  logic [NumW-1:0]     dist_num;
  logic [DivisorW-1:0] dist_den;
  logic [GapW-1:0]     dist_gap;

  logic             mean_valid;
  logic [MeanW-1:0] mean;
  logic [GapW-1:0]  mean_gap;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgReaction:   cfg_q.reaction_ms      <= cfg_data_i[11:0];
        CfgActivation: cfg_q.activation_ms    <= cfg_data_i[11:0];
        CfgPressure:   cfg_q.pressure_rise_ms <= cfg_data_i[11:0];
        CfgDecel:      cfg_q.decel_mm_s2      <= cfg_data_i[14:0];
        CfgSpread:     cfg_q.spread_fraction  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcp_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .valid_i(in_valid_i),
    .word_i (in_word_i),
    .valid_o(dist_valid),
    .num_o  (dist_num),
    .den_o  (dist_den),
    .gap_o  (dist_gap)
  );

  bcp_div #(
    .NW(NumW),
    .DW(DivisorW),
    .QW(MeanW),
    .SW(GapW)
  ) u_mean_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(dist_valid),
    .num_i  (dist_num),
    .den_i  (dist_den),
    .side_i (dist_gap),
    .valid_o(mean_valid),
    .quo_o  (mean),
    .side_o (mean_gap)
  );

  bcp_prob #(
    .Entries(CDF_TABLE_ENTRIES)
  ) u_prob (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .valid_i(mean_valid),
    .mean_i (mean),
    .gap_i  (mean_gap),
    .valid_o(out_valid_o),
    .word_o (out_word_o)
  );

`ifndef SYNTH
  a_zero_dist_prob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stop_distance_mm == '0 |-> out_word_o.collision_prob == '0)
    else $error("nonzero probability at zero distance");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");
`endif

endmodule

FILE: dv/braking_collision_probability_tb.sv
// Self-checking testbench of the braking collision probability block.
`timescale 1ns / 100ps

module braking_collision_probability_tb;
  import bcp_pkg::*;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned Latency = 49;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  braking_collision_probability #(.CDF_TABLE_ENTRIES(TableEntries)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o,
    .out_stall_i, .out_word_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  typedef struct {
    logic [19:0] gap;
    logic [15:0] speed;
    logic        known;
    out_word_t   res;
  } row_t;

  cfg_t brake_cfg;
  out_word_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned sat_seen = 0;
  longint unsigned cycles = 0;

  function automatic logic [15:0] tail_lookup(longint unsigned k);
    longint unsigned pos, j, r, hi, lo, v;
    pos = 64 * k;
    j = pos / TableEntries;
    r = pos % TableEntries;
    if (j >= KnotLast) return 16'd0;
    hi = TailKnots[j];
    lo = TailKnots[j + 1];
    v = hi * TableEntries - (hi - lo) * r;
    return 16'((v + TableEntries / 2) / TableEntries);
  endfunction

  function automatic out_word_t predict_braking(logic [19:0] gap, logic [15:0] speed);
    longint unsigned s, d, f, t, num, den, m, a, sg, tail, prob;
    out_word_t w;
    s = speed;
    d = (brake_cfg.decel_mm_s2 != 0) ? brake_cfg.decel_mm_s2 : 1;
    f = (brake_cfg.spread_fraction != 0) ? brake_cfg.spread_fraction : 1;
    t = 2 * brake_cfg.reaction_ms + 2 * brake_cfg.activation_ms + brake_cfg.pressure_rise_ms;
    num = 360 * s * t * d + 390625 * s * s;
    den = 663552 * d;
    m = (num + den / 2) / den;
    prob = 0;
    if (m != 0) begin
      a = (gap >= m) ? gap - m : m - gap;
      sg = f * m;
      tail = 0;
      if (a * 65536 < 8 * sg) tail = tail_lookup((a * 65536 * TableEntries) / (8 * sg));
      if (gap >= m) prob = tail;
      else begin
        prob = 65536 - tail;
        if (prob > 65535) prob = 65535;
      end
    end
    w.distance_saturated = (m > DistMax);
    w.stop_distance_mm = w.distance_saturated ? DistMax : m[23:0];
    w.collision_prob = prob[15:0];
    return w;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 8) return $urandom_range(10, 60);
    if ($urandom_range(0, 99) < 50) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver side: random stall, compare each word with the oldest prediction
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_checked <= words_checked + 1;
        if (pending_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected word %p", out_word_o);
        end else begin
          out_word_t exp_w;
          exp_w = pending_results.pop_front();
          if (exp_w.distance_saturated) sat_seen <= sat_seen + 1;
          if (out_word_o !== exp_w) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: dist %0d/%0d prob %0d/%0d sat %0b/%0b (exp/act)",
                       exp_w.stop_distance_mm, out_word_o.stop_distance_mm,
                       exp_w.collision_prob, out_word_o.collision_prob,
                       exp_w.distance_saturated, out_word_o.distance_saturated);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= idle_len();
        out_stall_i <= 1'b0;
      end
    end
  end

  // valid stays high from one word to the next unless a gap follows
  task automatic send_word(logic [19:0] gap, logic [15:0] speed, bit chk, out_word_t res);
    out_word_t p;
    int unsigned gap_cycles;
    gap_cycles = idle_len();
    if (gap_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    p = predict_braking(gap, speed);
    if (chk && p !== res) begin
      mismatches++;
      if (mismatches <= 10) $display("table row gap %0d speed %0d disagrees", gap, speed);
    end
    in_valid_i <= 1'b1;
    in_word_i <= '{gap_mm: gap, speed_kmh_q8: speed};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(p);
    words_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgReaction:   brake_cfg.reaction_ms = val[11:0];
      CfgActivation: brake_cfg.activation_ms = val[11:0];
      CfgPressure:   brake_cfg.pressure_rise_ms = val[11:0];
      CfgDecel:      brake_cfg.decel_mm_s2 = val[14:0];
      CfgSpread:     brake_cfg.spread_fraction = val;
      default: ;
    endcase
  endtask

  task automatic random_burst(int unsigned n);
    logic [19:0] g;
    logic [15:0] s;
    out_word_t p;
    for (int i = 0; i < n; i++) begin
      s = (i % 8 == 0) ? 16'($urandom) : 16'($urandom_range(0, 40000));
      // bias the gap near the predicted distance so the tail table is exercised
      p = predict_braking(20'd0, s);
      if ($urandom_range(0, 3) == 0 || p.distance_saturated) g = 20'($urandom);
      else g = 20'(int'(p.stop_distance_mm) + $urandom_range(0, 2 * p.stop_distance_mm / 3 + 2)
                    - int'(p.stop_distance_mm / 3));
      send_word(g, s, 1'b0, '0);
    end
  endtask

  row_t directed[$];

  initial begin
    brake_cfg = CfgReset;
    directed = '{
      '{20'd0, 16'd0, 1'b1, '{24'd0, 16'd0, 1'b0}},
      '{20'hFFFFF, 16'd0, 1'b1, '{24'd0, 16'd0, 1'b0}},
      '{20'd0, 16'hFFFF, 1'b0, '0},
      '{20'hFFFFF, 16'hFFFF, 1'b0, '0},
      '{20'd50000, 16'd25600, 1'b0, '0},
      '{20'd0, 16'd25600, 1'b0, '0},
      '{20'hFFFFF, 16'd25600, 1'b0, '0},
      '{20'd1, 16'd1, 1'b0, '0},
      '{20'h55555, 16'hAAAA, 1'b0, '0},
      '{20'hAAAAA, 16'h5555, 1'b0, '0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_word(directed[i].gap, directed[i].speed,
                                    directed[i].known, directed[i].res);
    random_burst(150);
    // extremes: longest times, weakest braking, widest spread -> saturation
    write_reg(CfgReaction, 16'hFFFF);
    write_reg(CfgActivation, 16'd4095);
    write_reg(CfgPressure, 16'd4095);
    write_reg(CfgDecel, 16'd0);
    write_reg(CfgSpread, 16'hFFFF);
    send_word(20'd0, 16'hFFFF, 1'b0, '0);
    random_burst(150);
    // zero times, a deceleration of 20000, zero spread
    write_reg(CfgReaction, 16'd0);
    write_reg(CfgActivation, 16'd0);
    write_reg(CfgPressure, 16'd0);
    write_reg(CfgDecel, 16'd20000);
    write_reg(CfgSpread, 16'd0);
    write_reg(3'd7, 16'h1234);
    random_burst(150);
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(CfgReaction, 16'($urandom));
      write_reg(CfgActivation, 16'($urandom));
      write_reg(CfgPressure, 16'($urandom));
      write_reg(CfgDecel, 16'($urandom_range(1, 20000)));
      write_reg(CfgSpread, 16'($urandom));
      write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      random_burst(150);
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("sent %0d words, checked %0d, %0d saturated, %0d mismatches",
             words_sent, words_checked, sat_seen, mismatches);
    $display("covered five register settings including both extremes");
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
